// ----- rtl/core/rrab_pkg.sv -----
package rrab_pkg;

    // geometry and fixed-point sizing
    localparam int SQRT_FRAC_BITS   = 8;
    localparam int MAX_SCREEN_WIDTH = 512;

    localparam int COL_W   = 9;
    localparam int LEFT_W  = 11;
    localparam int DIM_W   = 9;
    localparam int RAD_CFG_W = 8;
    localparam int PIX_W   = 16;
    localparam int SCR_W   = 10;
    localparam int POS_W   = 12;
    localparam int COV_W   = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int ONE    = 1 << SQRT_FRAC_BITS;
    localparam int AX_W   = 10;                        // |q| never exceeds 1023
    localparam int SQ_W   = 2 * AX_W;
    localparam int SUM_W  = SQ_W + 1;
    localparam int ROOT_W = (SUM_W + 2 * SQRT_FRAC_BITS + 1) / 2;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 3;
    localparam int C_W    = ROOT_W + 3;
    localparam int CV_W   = SQRT_FRAC_BITS + 2;        // holds 0..2*ONE
    localparam int CP_W   = CV_W + COV_W + 1;
    localparam int SWC_W  = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOX_LEFT      = 3'd0,
        CFG_BOX_TOP       = 3'd1,
        CFG_BOX_WIDTH     = 3'd2,
        CFG_BOX_HEIGHT    = 3'd3,
        CFG_CORNER_RADIUS = 3'd4,
        CFG_FILL_COLOR    = 3'd5,
        CFG_SCREEN_WIDTH  = 3'd6,
        CFG_SCREEN_HEIGHT = 3'd7
    } t_cfg_idx;

    // per-pixel data riding alongside the square root
    typedef struct packed {
        logic signed [POS_W-1:0] sx;
        logic signed [POS_W-1:0] sy;
        logic [PIX_W-1:0]        bg;
        logic                    on;
        logic signed [POS_W-1:0] negi;
    } t_side;

endpackage

// ----- rtl/core/rrab_if.sv -----
interface rrab_pix_if;
    import rrab_pkg::*;
    logic               valid;
    logic               ready;
    logic [COL_W-1:0]   pixel_col;
    logic [COL_W-1:0]   pixel_row;
    logic [PIX_W-1:0]   background_pixel;

    modport source (output valid, pixel_col, pixel_row, background_pixel, input ready);
    modport sink   (input valid, pixel_col, pixel_row, background_pixel, output ready);
endinterface

interface rrab_res_if;
    import rrab_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    write_enable;
    logic [PIX_W-1:0]        out_pixel;
    logic [COV_W-1:0]        coverage;
    logic signed [POS_W-1:0] screen_col;
    logic signed [POS_W-1:0] screen_row;

    modport source (output valid, write_enable, out_pixel, coverage, screen_col, screen_row,
                    input ready);
    modport sink   (input valid, write_enable, out_pixel, coverage, screen_col, screen_row,
                    output ready);
endinterface

interface rrab_cfg_if;
    import rrab_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/rrab_sqrt.sv -----
module rrab_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_valid,
    input  logic [rrab_pkg::SUM_W-1:0]    i_rad,
    input  rrab_pkg::t_side               i_side,
    output logic                          o_valid,
    output logic [rrab_pkg::ROOT_W-1:0]   o_root,
    output rrab_pkg::t_side               o_side
);
    import rrab_pkg::*;

    // one result bit per stage, restoring recurrence
    logic [RAD_W-1:0]  r_rad  [0:ROOT_W-1];
    logic [REM_W-1:0]  r_rem  [0:ROOT_W-1];
    logic [ROOT_W-1:0] r_root [0:ROOT_W-1];
    t_side             r_side [0:ROOT_W-1];
    logic [ROOT_W-1:0] r_vld;

    logic [RAD_W-1:0]  a_rad  [0:ROOT_W-1];
    logic [REM_W-1:0]  a_rem  [0:ROOT_W-1];
    logic [ROOT_W-1:0] a_root [0:ROOT_W-1];
    t_side             a_side [0:ROOT_W-1];
    logic [ROOT_W-1:0] a_vld;

    logic [RAD_W-1:0]  n_rad  [0:ROOT_W-1];
    logic [REM_W-1:0]  n_rem  [0:ROOT_W-1];
    logic [ROOT_W-1:0] n_root [0:ROOT_W-1];

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++) begin : g_stage
            logic [REM_W-1:0] w_acc;
            logic [REM_W-1:0] w_trial;
            logic             w_fit;

            if (k == 0) begin : g_first
                assign a_rad[k]  = RAD_W'(i_rad) << (2 * SQRT_FRAC_BITS);
                assign a_rem[k]  = '0;
                assign a_root[k] = '0;
                assign a_side[k] = i_side;
                assign a_vld[k]  = i_valid;
            end else begin : g_next
                assign a_rad[k]  = r_rad[k-1];
                assign a_rem[k]  = r_rem[k-1];
                assign a_root[k] = r_root[k-1];
                assign a_side[k] = r_side[k-1];
                assign a_vld[k]  = r_vld[k-1];
            end

            assign w_acc   = {a_rem[k][REM_W-3:0], a_rad[k][RAD_W-1 -: 2]};
            assign w_trial = REM_W'({a_root[k], 2'b01});
            assign w_fit   = (w_acc >= w_trial);
            assign n_rem[k]  = w_fit ? (w_acc - w_trial) : w_acc;
            assign n_root[k] = {a_root[k][ROOT_W-2:0], w_fit};
            assign n_rad[k]  = a_rad[k] << 2;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < ROOT_W; i++) begin
                r_rad[i]  <= n_rad[i];
                r_rem[i]  <= n_rem[i];
                r_root[i] <= n_root[i];
                r_side[i] <= a_side[i];
            end
        end
    end

    assign o_valid = r_vld[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ROOT_W-1] |-> r_rem[ROOT_W-1] <= (REM_W'(r_root[ROOT_W-1]) << 1))
        else $error("sqrt remainder above twice the root");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> $stable(o_root) && $stable(o_valid))
        else $error("sqrt output moved during a stall");

    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && r_vld[ROOT_W-2] |=> o_valid)
        else $error("sqrt lost a beat");

endmodule

// ----- rtl/core/rounded_rect_aa_blend.sv -----
// Anti-aliased rounded-rectangle fill with RGB565 blending. Each input beat is one pixel
// position inside the box plus the framebuffer pixel there; each output beat is the blended
// pixel, its coverage, its screen position and a write enable. The datapath is a single
// pipeline that takes one pixel every clock while the output is not stalled; the bulk of
// its length is the square root, built as one register stage per result bit. A stall on the
// output freezes the whole pipe, so input ready follows output ready while the last stage
// holds a result.
// Configuration writes are taken every cycle and must only be made while no pixel is in flight.
module rounded_rect_aa_blend (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rrab_pix_if.sink  i_pix,
    rrab_cfg_if.sink  i_cfg,
    rrab_res_if.source o_res
);
    import rrab_pkg::*;

    function automatic logic [5:0] div255(input logic [13:0] x);
        logic [15:0] t;
        t = 16'(x) + 16'(x >> 8) + 16'd1;
        return t[13:8];
    endfunction

    // configuration
    logic signed [LEFT_W-1:0] r_left, r_top;
    logic [DIM_W-1:0]         r_w, r_h;
    logic [RAD_CFG_W-1:0]     r_r;
    logic [PIX_W-1:0]         r_fill;
    logic [SCR_W-1:0]         r_sw, r_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_top  <= '0;
            r_w    <= DIM_W'(1);
            r_h    <= DIM_W'(1);
            r_r    <= '0;
            r_fill <= '0;
            r_sw   <= SCR_W'(320);
            r_sh   <= SCR_W'(240);
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_BOX_LEFT:      r_left <= i_cfg.data[LEFT_W-1:0];
                CFG_BOX_TOP:       r_top  <= i_cfg.data[LEFT_W-1:0];
                CFG_BOX_WIDTH:     r_w    <= i_cfg.data[DIM_W-1:0];
                CFG_BOX_HEIGHT:    r_h    <= i_cfg.data[DIM_W-1:0];
                CFG_CORNER_RADIUS: r_r    <= i_cfg.data[RAD_CFG_W-1:0];
                CFG_FILL_COLOR:    r_fill <= i_cfg.data[PIX_W-1:0];
                CFG_SCREEN_WIDTH:  r_sw   <= i_cfg.data[SCR_W-1:0];
                CFG_SCREEN_HEIGHT: r_sh   <= i_cfg.data[SCR_W-1:0];
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;

    // values derived from static config
    logic [RAD_CFG_W-1:0] rc;
    logic [DIM_W-1:0]     slack_x, slack_y;
    logic                 sw_ok, box_empty;

    always_comb begin
        rc = r_r;
        if (rc > r_w[DIM_W-1:1]) rc = r_w[DIM_W-1:1];
        if (rc > r_h[DIM_W-1:1]) rc = r_h[DIM_W-1:1];
    end

    assign slack_x   = r_w - {rc, 1'b0};
    assign slack_y   = r_h - {rc, 1'b0};
    assign sw_ok     = SWC_W'(r_sw) <= SWC_W'(MAX_SCREEN_WIDTH);
    assign box_empty = (r_w == '0) || (r_h == '0);

    // global advance: the whole pipe moves unless the output is stalled
    logic adv, accept;
    logic r_o_vld;

    assign adv         = !r_o_vld || o_res.ready;
    assign i_pix.ready = adv;
    assign accept      = i_pix.valid && adv;

    // stage 1: centre offsets in half pixels, screen position
    logic                    r_s1_vld;
    logic signed [POS_W-1:0] r_s1_dx, r_s1_dy, r_s1_sx, r_s1_sy;
    logic [PIX_W-1:0]        r_s1_bg;
    logic signed [POS_W-1:0] n_s1_dx, n_s1_dy, n_s1_sx, n_s1_sy;

    assign n_s1_dx = $signed({2'b00, i_pix.pixel_col, 1'b1}) - $signed({3'b000, r_w});
    assign n_s1_dy = $signed({2'b00, i_pix.pixel_row, 1'b1}) - $signed({3'b000, r_h});
    assign n_s1_sx = POS_W'(r_left) + $signed({3'b000, i_pix.pixel_col});
    assign n_s1_sy = POS_W'(r_top)  + $signed({3'b000, i_pix.pixel_row});

    // stage 2: q vector, clipping
    logic                    r_s2_vld, r_s2_on;
    logic signed [POS_W-1:0] r_s2_qx, r_s2_qy, r_s2_sx, r_s2_sy;
    logic [PIX_W-1:0]        r_s2_bg;
    logic signed [POS_W-1:0] adx, ady, n_s2_qx, n_s2_qy;
    logic                    n_s2_on;

    assign adx     = r_s1_dx[POS_W-1] ? -r_s1_dx : r_s1_dx;
    assign ady     = r_s1_dy[POS_W-1] ? -r_s1_dy : r_s1_dy;
    assign n_s2_qx = adx - $signed({3'b000, slack_x});
    assign n_s2_qy = ady - $signed({3'b000, slack_y});
    assign n_s2_on = sw_ok
                  && !r_s1_sx[POS_W-1] && (r_s1_sx < $signed({2'b00, r_sw}))
                  && !r_s1_sy[POS_W-1] && (r_s1_sy < $signed({2'b00, r_sh}));

    // stage 3: squares, inside term
    logic                    r_s3_vld, r_s3_on;
    logic [SQ_W-1:0]         r_s3_sqx, r_s3_sqy;
    logic signed [POS_W-1:0] r_s3_negi, r_s3_sx, r_s3_sy;
    logic [PIX_W-1:0]        r_s3_bg;
    logic [AX_W-1:0]         ax, ay;
    logic signed [POS_W-1:0] inner;

    assign ax    = (r_s2_qx > 0) ? r_s2_qx[AX_W-1:0] : '0;
    assign ay    = (r_s2_qy > 0) ? r_s2_qy[AX_W-1:0] : '0;
    assign inner = (r_s2_qx > r_s2_qy) ? r_s2_qx : r_s2_qy;

    // stage 4: radicand
    logic             r_s4_vld;
    logic [SUM_W-1:0] r_s4_sum;
    t_side            r_s4_side;

    // square root
    logic              sq_vld;
    logic [ROOT_W-1:0] sq_len;
    t_side             sq_side;

    rrab_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r_s4_vld),
        .i_rad   (r_s4_sum),
        .i_side  (r_s4_side),
        .o_valid (sq_vld),
        .o_root  (sq_len),
        .o_side  (sq_side)
    );

    // stage 5: doubled coverage c = 1 - distance, clamped to [0, 2]
    logic                r_s5_vld;
    logic [CV_W-1:0]     r_s5_c;
    t_side               r_s5_side;
    logic signed [C_W-1:0] craw;
    logic [CV_W-1:0]     n_s5_c;

    assign craw = $signed(C_W'(ONE)) - $signed(C_W'(sq_len))
                + $signed(C_W'(rc) << (SQRT_FRAC_BITS + 1))
                - (C_W'(sq_side.negi) <<< SQRT_FRAC_BITS);

    always_comb begin
        if (craw < 0)
            n_s5_c = '0;
        else if (craw > $signed(C_W'(2 * ONE)))
            n_s5_c = CV_W'(2 * ONE);
        else
            n_s5_c = craw[CV_W-1:0];
    end

    // stage 6: 8-bit coverage
    logic                    r_s6_vld, r_s6_we;
    logic [COV_W-1:0]        r_s6_cov;
    logic signed [POS_W-1:0] r_s6_sx, r_s6_sy;
    logic [PIX_W-1:0]        r_s6_bg;
    logic [CP_W-1:0]         cprod, cshift;
    logic [COV_W-1:0]        n_s6_cov;

    assign cprod  = (CP_W'(r_s5_c) << COV_W) - CP_W'(r_s5_c) + CP_W'(ONE);
    assign cshift = cprod >> (SQRT_FRAC_BITS + 1);

    always_comb begin
        if (box_empty)
            n_s6_cov = '0;
        else if (cshift > CP_W'(255))
            n_s6_cov = '1;
        else
            n_s6_cov = cshift[COV_W-1:0];
    end

    // stage 7: channel products
    logic                    r_s7_vld, r_s7_we, r_s7_full;
    logic [COV_W-1:0]        r_s7_cov;
    logic [12:0]             r_s7_r, r_s7_b;
    logic [13:0]             r_s7_g;
    logic signed [POS_W-1:0] r_s7_sx, r_s7_sy;
    logic [PIX_W-1:0]        r_s7_bg;
    logic [COV_W-1:0]        na;

    assign na = 8'd255 - r_s6_cov;

    // stage 8: output register
    logic                    r_o_we;
    logic [PIX_W-1:0]        r_o_pix;
    logic [COV_W-1:0]        r_o_cov;
    logic signed [POS_W-1:0] r_o_sx, r_o_sy;
    logic [PIX_W-1:0]        n_o_pix;
    logic [5:0]              q_r, q_g, q_b;

    assign q_r = div255(14'(r_s7_r));
    assign q_g = div255(r_s7_g);
    assign q_b = div255(14'(r_s7_b));

    always_comb begin
        if (!r_s7_we)
            n_o_pix = r_s7_bg;
        else if (r_s7_full)
            n_o_pix = r_fill;
        else
            n_o_pix = {q_r[4:0], q_g, q_b[4:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
            r_s6_vld <= 1'b0;
            r_s7_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else if (adv) begin
            r_s1_vld <= accept;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
            r_s5_vld <= sq_vld;
            r_s6_vld <= r_s5_vld;
            r_s7_vld <= r_s6_vld;
            r_o_vld  <= r_s7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_dx <= n_s1_dx;
            r_s1_dy <= n_s1_dy;
            r_s1_sx <= n_s1_sx;
            r_s1_sy <= n_s1_sy;
            r_s1_bg <= i_pix.background_pixel;

            r_s2_qx <= n_s2_qx;
            r_s2_qy <= n_s2_qy;
            r_s2_on <= n_s2_on;
            r_s2_sx <= r_s1_sx;
            r_s2_sy <= r_s1_sy;
            r_s2_bg <= r_s1_bg;

            r_s3_sqx  <= SQ_W'(ax) * SQ_W'(ax);
            r_s3_sqy  <= SQ_W'(ay) * SQ_W'(ay);
            r_s3_negi <= inner[POS_W-1] ? inner : '0;
            r_s3_on   <= r_s2_on;
            r_s3_sx   <= r_s2_sx;
            r_s3_sy   <= r_s2_sy;
            r_s3_bg   <= r_s2_bg;

            r_s4_sum       <= SUM_W'(r_s3_sqx) + SUM_W'(r_s3_sqy);
            r_s4_side.sx   <= r_s3_sx;
            r_s4_side.sy   <= r_s3_sy;
            r_s4_side.bg   <= r_s3_bg;
            r_s4_side.on   <= r_s3_on;
            r_s4_side.negi <= r_s3_negi;

            r_s5_c    <= n_s5_c;
            r_s5_side <= sq_side;

            r_s6_cov <= n_s6_cov;
            r_s6_we  <= r_s5_side.on && (n_s6_cov != '0);
            r_s6_sx  <= r_s5_side.sx;
            r_s6_sy  <= r_s5_side.sy;
            r_s6_bg  <= r_s5_side.bg;

            r_s7_r    <= 13'(r_fill[15:11]) * 13'(r_s6_cov) + 13'(r_s6_bg[15:11]) * 13'(na);
            r_s7_g    <= 14'(r_fill[10:5])  * 14'(r_s6_cov) + 14'(r_s6_bg[10:5])  * 14'(na);
            r_s7_b    <= 13'(r_fill[4:0])   * 13'(r_s6_cov) + 13'(r_s6_bg[4:0])   * 13'(na);
            r_s7_full <= (r_s6_cov == 8'd255);
            r_s7_we   <= r_s6_we;
            r_s7_cov  <= r_s6_cov;
            r_s7_sx   <= r_s6_sx;
            r_s7_sy   <= r_s6_sy;
            r_s7_bg   <= r_s6_bg;

            r_o_we  <= r_s7_we;
            r_o_pix <= n_o_pix;
            r_o_cov <= r_s7_cov;
            r_o_sx  <= r_s7_sx;
            r_o_sy  <= r_s7_sy;
        end
    end

    assign o_res.valid        = r_o_vld;
    assign o_res.write_enable = r_o_we;
    assign o_res.out_pixel    = r_o_pix;
    assign o_res.coverage     = r_o_cov;
    assign o_res.screen_col   = r_o_sx;
    assign o_res.screen_row   = r_o_sy;

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld && !o_res.ready |-> !i_pix.ready)
        else $error("input taken while output stalled");

    a_we_needs_cov: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld && r_o_we |-> r_o_cov != '0)
        else $error("write enabled with zero coverage");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix.valid && i_pix.ready |=> r_s1_vld)
        else $error("accepted beat missing from first stage");

    a_c_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s5_vld |-> r_s5_c <= CV_W'(2 * ONE))
        else $error("doubled coverage out of range");

endmodule
